// File: sv/fdl_pkg.sv
// Shared types, constants and helpers for the fractional delay line.
package fdl_pkg;

    localparam int MAX_DELAY  = 4096;
    localparam int ADDR_W     = $clog2(MAX_DELAY);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 16;
    localparam int WHOLE_W    = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = SAMPLE_W + FRAC_W + 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [FRAC_W-1:0]          frac_t;
    typedef logic [WHOLE_W-1:0]         whole_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DELAY_WHOLE = 2'd0,
        REG_DELAY_FRAC  = 2'd1
    } cfg_reg_t;

    // Ring memory access for one cycle.
    typedef struct packed {
        logic    we;
        addr_t   waddr;
        sample_t wdata;
        logic    re;
        addr_t   raddr0;
        addr_t   raddr1;
    } mem_req_t;

    // Controller status seen by the top level.
    typedef struct packed {
        logic  clearing;
        addr_t rd_ptr;
        addr_t wr_ptr;
        len_t  line_len;
    } ctrl_status_t;

    // Line length: max(1, whole + (frac != 0)), capped at MAX_DELAY.
    function automatic len_t line_length(input whole_t whole, input frac_t frac);
        logic [WHOLE_W:0] sum;
        sum = {1'b0, whole} + {{WHOLE_W{1'b0}}, (frac != '0)};
        if (sum == '0) begin
            return len_t'(1);
        end else if (sum > (WHOLE_W + 1)'(MAX_DELAY)) begin
            return len_t'(MAX_DELAY);
        end else begin
            return sum[LEN_W-1:0];
        end
    endfunction

endpackage

// File: sv/fdl_ring_ram.sv
// Ring sample memory: one write port, two registered read ports, read-first.
module fdl_ring_ram (
    input  logic               aclk,
    input  fdl_pkg::mem_req_t  mem_req,
    output fdl_pkg::sample_t   rd0,
    output fdl_pkg::sample_t   rd1
);
    import fdl_pkg::*;

    sample_t mem [MAX_DELAY];
    sample_t rd0_reg;
    sample_t rd1_reg;

    // Reads return the contents before a same-cycle write.
    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re) begin
            rd0_reg <= mem[mem_req.raddr0];
            rd1_reg <= mem[mem_req.raddr1];
        end
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

// File: sv/fdl_ctrl.sv
// Configuration registers, ring pointers and the post-reset clearing sweep.
module fdl_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fdl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_accept,
    input  fdl_pkg::sample_t                  sample_in,
    output fdl_pkg::mem_req_t                 mem_req,
    output fdl_pkg::ctrl_status_t             status,
    output fdl_pkg::frac_t                    frac,
    output logic                              unit_len
);
    import fdl_pkg::*;

    whole_t whole_reg, whole_next;
    frac_t  frac_reg, frac_next;
    len_t   len_reg, len_next;
    addr_t  rp_reg, rp_next;
    addr_t  wp_reg, wp_next;
    logic   clr_busy_reg, clr_busy_next;
    addr_t  clr_addr_reg, clr_addr_next;
    addr_t  rp_inc;
    addr_t  wp_inc;

    // Pointer advance modulo the line length.
    assign rp_inc = ({1'b0, rp_reg} + len_t'(1) == len_reg) ? '0 : rp_reg + addr_t'(1);
    assign wp_inc = ({1'b0, wp_reg} + len_t'(1) == len_reg) ? '0 : wp_reg + addr_t'(1);

    always_comb begin
        whole_next = whole_reg;
        frac_next  = frac_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DELAY_WHOLE: whole_next = cfg_wr_data[WHOLE_W-1:0];
                REG_DELAY_FRAC:  frac_next  = cfg_wr_data[FRAC_W-1:0];
                default: ;
            endcase
        end
        len_next = line_length(whole_next, frac_next);

        rp_next = rp_reg;
        wp_next = wp_reg;
        if (len_next != len_reg) begin
            rp_next = '0;
            wp_next = ADDR_W'(len_next - len_t'(1));
        end else if (s_accept && len_reg != len_t'(1)) begin
            rp_next = rp_inc;
            wp_next = wp_inc;
        end
    end

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + addr_t'(1);
            if (clr_addr_reg == addr_t'(MAX_DELAY - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            whole_reg    <= '0;
            frac_reg     <= '0;
            len_reg      <= len_t'(1);
            rp_reg       <= '0;
            wp_reg       <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            whole_reg    <= whole_next;
            frac_reg     <= frac_next;
            len_reg      <= len_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Unit length: wp and rp sit at entry 0, so the plain write path serves it.
    always_comb begin
        mem_req.raddr0 = rp_reg;
        mem_req.raddr1 = rp_inc;
        if (clr_busy_reg) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_addr_reg;
            mem_req.wdata = '0;
            mem_req.re    = 1'b0;
        end else begin
            mem_req.we    = s_accept;
            mem_req.waddr = wp_reg;
            mem_req.wdata = sample_in;
            mem_req.re    = s_accept;
        end
    end

    assign status.clearing = clr_busy_reg;
    assign status.rd_ptr   = rp_reg;
    assign status.wr_ptr   = wp_reg;
    assign status.line_len = len_reg;
    assign frac            = frac_reg;
    assign unit_len        = (len_reg == len_t'(1));

endmodule

// File: sv/fdl_interp.sv
// Interpolation pipeline: multiply stage, add stage and output register.
module fdl_interp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               s_accept,
    input  fdl_pkg::sample_t   sample_in,
    input  fdl_pkg::frac_t     frac,
    input  logic               unit_len,
    input  fdl_pkg::sample_t   rd0,
    input  fdl_pkg::sample_t   rd1,
    output logic               out_valid,
    output fdl_pkg::sample_t   out_data
);
    import fdl_pkg::*;

    logic    a_valid_reg;
    sample_t a_sample_reg;
    frac_t   a_frac_reg;
    logic    a_unit_reg;

    logic                     b_valid_reg;
    sample_t                  b_r0_reg;
    logic signed [PROD_W-1:0] b_prod_reg;

    logic    out_valid_reg;
    sample_t out_data_reg;

    sample_t                    r0_sel;
    logic signed [FRAC_W:0]     frac_sel;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    sample_t                    y;

    // Unit length passes the sample through with a zero weight.
    assign r0_sel   = a_unit_reg ? a_sample_reg : rd0;
    assign frac_sel = a_unit_reg ? '0 : $signed({1'b0, a_frac_reg});
    assign diff     = $signed({rd1[SAMPLE_W-1], rd1}) - $signed({r0_sel[SAMPLE_W-1], r0_sel});
    assign prod     = PROD_W'(diff * frac_sel);

    // Floor shift then add; the sum stays within r0..r1 so the low bits suffice.
    assign y = b_r0_reg + b_prod_reg[FRAC_W +: SAMPLE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg   <= s_accept;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_sample_reg <= sample_in;
            a_frac_reg   <= frac;
            a_unit_reg   <= unit_len;
        end
        if (advance) begin
            b_r0_reg     <= r0_sel;
            b_prod_reg   <= prod;
            out_data_reg <= y;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: sv/fractional_delay_line.sv
// Top level of the linear-interpolated fractional delay line.
//
//  Channel   Ports                                  Direction  Content
//  input     s_tvalid s_tready s_tdata[23:0]        in         sample_in
//  result    m_tvalid m_tready m_tdata[23:0]        out        sample_out
//  config    cfg_wr_en cfg_addr[1:0] cfg_wr_data    in         0 delay_whole, 1 delay_frac
//
// Throughput: one transaction per cycle unless m_tready stalls or the clearing sweep runs.
// Pipeline: three register stages (a, b, output); m_tvalid rises once a sample reaches the output.
// The ring memory does two reads and one write per sample in the accept cycle;
// reads return the old contents, so back-to-back samples need no forwarding.
// After reset all 4096 memory entries are swept to zero; s_tready stays low meanwhile.
// A stall on m_tready freezes the whole pipeline and drops s_tready.
module fractional_delay_line (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fdl_pkg::SAMPLE_W-1:0]   s_tdata,     // [23:0] sample_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fdl_pkg::SAMPLE_W-1:0]   m_tdata,     // [23:0] sample_out
    input  logic                           cfg_wr_en,
    input  logic [fdl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [fdl_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import fdl_pkg::*;

    logic         advance;
    logic         s_accept;
    mem_req_t     mem_req;
    ctrl_status_t status;
    frac_t        frac;
    logic         unit_len;
    sample_t      rd0;
    sample_t      rd1;
    sample_t      out_data;

    // Pipeline moves unless the output register holds an untaken result.
    assign advance  = !(m_tvalid && !m_tready);
    assign s_tready = advance && !status.clearing;
    assign s_accept = s_tvalid && s_tready;

    fdl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_accept    (s_accept),
        .sample_in   (sample_t'(s_tdata)),
        .mem_req     (mem_req),
        .status      (status),
        .frac        (frac),
        .unit_len    (unit_len)
    );

    fdl_ring_ram u_ram (
        .aclk    (aclk),
        .mem_req (mem_req),
        .rd0     (rd0),
        .rd1     (rd1)
    );

    fdl_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .s_accept  (s_accept),
        .sample_in (sample_t'(s_tdata)),
        .frac      (frac),
        .unit_len  (unit_len),
        .rd0       (rd0),
        .rd1       (rd1),
        .out_valid (m_tvalid),
        .out_data  (out_data)
    );

    assign m_tdata = out_data;

`ifndef SYNTH
    // No transaction is taken during the clearing sweep.
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_tready)
        else $error("input accepted during memory clear");

    // Pointers stay inside the active line.
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, status.rd_ptr} < status.line_len) && ({1'b0, status.wr_ptr} < status.line_len))
        else $error("ring pointer outside line length");

    // Clearing runs once after reset and never restarts.
    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.clearing |=> !status.clearing)
        else $error("memory clear restarted");

    // An accepted sample with a free pipeline writes the ring memory.
    a_accept_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (mem_req.we && mem_req.re && mem_req.wdata == sample_t'(s_tdata)))
        else $error("accepted sample not written to ring");
`endif

endmodule
